/* rtl/scr_pkg.sv */
// ----------------------------------------------------------------------------
// scr_pkg
// shared types, codes and helpers for the submission/completion ring controller
// ----------------------------------------------------------------------------
package scr_pkg;

  // field widths fixed by the item layout
  localparam int unsigned SlotW   = 10;
  localparam int unsigned StatusW = 8;
  localparam int unsigned QnumW   = 16;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned DbIdxW  = 16;
  localparam int unsigned DbW     = 64;
  localparam int unsigned OutcomeW = 3;

  // stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 88;

  // apb register map
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  typedef enum logic [1:0] {
    REG_QUEUE_NUMBER  = 2'd0,
    REG_SUBMIT_CODE   = 2'd1,
    REG_COMPLETE_CODE = 2'd2
  } reg_idx_e;

  // request kind carried in the input tuser
  typedef enum logic {
    CMD_SUBMIT = 1'b0,
    CMD_POLL   = 1'b1
  } command_e;

  // result kind carried in the output tuser
  typedef enum logic [OutcomeW-1:0] {
    OUT_SUBMITTED = 3'd0,
    OUT_BUSY      = 3'd1,
    OUT_CPL_OK    = 3'd2,
    OUT_CPL_ERR   = 3'd3,
    OUT_NONE      = 3'd4
  } outcome_e;

  typedef struct packed {
    logic [QnumW-1:0] queue_number;
    logic [CodeW-1:0] submit_code;
    logic [CodeW-1:0] complete_code;
  } cfg_t;

  typedef struct packed {
    command_e           command;
    logic               entry_phase;
    logic [SlotW-1:0]   entry_sq_slot;
    logic [StatusW-1:0] entry_status;
  } item_t;

  typedef struct packed {
    outcome_e         outcome;
    logic [SlotW-1:0] slot_index;
    logic [SlotW-1:0] done_sq_slot;
    logic             doorbell_valid;
    logic [DbW-1:0]   doorbell_word;
  } result_t;

  // doorbell: queue number, command code, new index, zero priority
  function automatic logic [DbW-1:0] make_doorbell(input logic [QnumW-1:0]  qnum,
                                                   input logic [CodeW-1:0]  code,
                                                   input logic [DbIdxW-1:0] idx);
    make_doorbell = {16'h0000, idx, 8'h00, code, qnum};
  endfunction

endpackage

/* rtl/scr_regs.sv */
// ----------------------------------------------------------------------------
// scr_regs
// apb configuration registers: queue number and the two doorbell codes
// ----------------------------------------------------------------------------
module scr_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [scr_pkg::AddrW-1:0]  paddr,
  input  logic [scr_pkg::DataW-1:0]  pwdata,
  output logic [scr_pkg::DataW-1:0]  prdata,
  output logic                       pready,
  output scr_pkg::cfg_t              cfg_o
);
  import scr_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.queue_number  <= '0;
      cfg_q.submit_code   <= '0;
      cfg_q.complete_code <= CodeW'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_QUEUE_NUMBER:  cfg_q.queue_number  <= pwdata[QnumW-1:0];
        REG_SUBMIT_CODE:   cfg_q.submit_code   <= pwdata[CodeW-1:0];
        REG_COMPLETE_CODE: cfg_q.complete_code <= pwdata[CodeW-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_QUEUE_NUMBER:  prdata = DataW'(cfg_q.queue_number);
      REG_SUBMIT_CODE:   prdata = DataW'(cfg_q.submit_code);
      REG_COMPLETE_CODE: prdata = DataW'(cfg_q.complete_code);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/scr_engine.sv */
// ----------------------------------------------------------------------------
// scr_engine
// ring pointers, full flag and phase, with the per-item result logic
// ----------------------------------------------------------------------------
module scr_engine #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  scr_pkg::item_t  item_i,
  input  scr_pkg::cfg_t   cfg_i,
  output scr_pkg::result_t result_o
);
  import scr_pkg::*;

  localparam int unsigned IdxW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(RING_DEPTH - 1);

  logic [IdxW-1:0] sq_tail_q, sq_tail_d;
  logic [IdxW-1:0] sq_head_q, sq_head_d;
  logic [IdxW-1:0] cq_head_q, cq_head_d;
  logic            phase_q, phase_d;
  logic            full_q, full_d;

  logic [IdxW-1:0] tail_next, head_next;
  logic [31:0]     tail_ext, tail_next_ext, head_ext, head_next_ext;

  // wrapping increments
  assign tail_next = (sq_tail_q == LastIdx) ? '0 : sq_tail_q + IdxW'(1);
  assign head_next = (cq_head_q == LastIdx) ? '0 : cq_head_q + IdxW'(1);

  assign tail_ext      = 32'(sq_tail_q);
  assign tail_next_ext = 32'(tail_next);
  assign head_ext      = 32'(cq_head_q);
  assign head_next_ext = 32'(head_next);

  // result and next state
  always_comb begin
    sq_tail_d = sq_tail_q;
    sq_head_d = sq_head_q;
    cq_head_d = cq_head_q;
    phase_d   = phase_q;
    full_d    = full_q;
    result_o  = '{outcome: OUT_NONE, default: '0};
    case (item_i.command)
      CMD_SUBMIT: begin
        if (full_q) begin
          result_o.outcome = OUT_BUSY;
        end else begin
          result_o.outcome        = OUT_SUBMITTED;
          result_o.slot_index     = tail_ext[SlotW-1:0];
          result_o.doorbell_valid = 1'b1;
          result_o.doorbell_word  = make_doorbell(cfg_i.queue_number, cfg_i.submit_code,
                                                  tail_next_ext[DbIdxW-1:0]);
          sq_tail_d = tail_next;
          if (tail_next == sq_head_q) begin
            full_d = 1'b1;
          end
        end
      end
      CMD_POLL: begin
        if (item_i.entry_phase != phase_q) begin
          result_o.outcome = OUT_NONE;
        end else if (item_i.entry_status != '0) begin
          result_o.outcome      = OUT_CPL_ERR;
          result_o.slot_index   = head_ext[SlotW-1:0];
          result_o.done_sq_slot = item_i.entry_sq_slot;
        end else begin
          result_o.outcome        = OUT_CPL_OK;
          result_o.slot_index     = head_ext[SlotW-1:0];
          result_o.done_sq_slot   = item_i.entry_sq_slot;
          result_o.doorbell_valid = 1'b1;
          result_o.doorbell_word  = make_doorbell(cfg_i.queue_number, cfg_i.complete_code,
                                                  head_next_ext[DbIdxW-1:0]);
          full_d    = 1'b0;
          cq_head_d = head_next;
          sq_head_d = head_next;
          if (cq_head_q == LastIdx) begin
            phase_d = ~phase_q;
          end
        end
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_tail_q <= '0;
      sq_head_q <= '0;
      cq_head_q <= '0;
      phase_q   <= 1'b1;
      full_q    <= 1'b0;
    end else if (step_i) begin
      sq_tail_q <= sq_tail_d;
      sq_head_q <= sq_head_d;
      cq_head_q <= cq_head_d;
      phase_q   <= phase_d;
      full_q    <= full_d;
    end
  end

endmodule

/* rtl/sq_cq_ring_controller.sv */
// ----------------------------------------------------------------------------
// sq_cq_ring_controller
// host-side submission/completion ring controller with phase-bit completions
// ----------------------------------------------------------------------------
//  channel   | direction | carries
//  s_axis    | in        | tuser command, tdata phase / sq slot / status
//  m_axis    | out       | tuser outcome, tdata slots / doorbell flag / word
//  apb       | in        | queue number, submit code, complete code
//
//  one transfer in and one out per cycle when sustained and the result is not
//  stalled, set by the single result logic pass between the input register
//  and the result register. an input transfer loads the input register, and
//  its result loads the result register when the item steps.
//  rst_ni clears the ring pointers, full flag and valid flags; phase resets to one.
//  a stalled result holds the pipeline; the input register stays free to take
//  a transfer whenever it is empty or moving on.
// ----------------------------------------------------------------------------
module sq_cq_ring_controller #(
  parameter int unsigned RING_DEPTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] entry_phase, [10:1] entry_sq_slot, [18:11] entry_status, rest zero
  input  logic [scr_pkg::InDataW-1:0]   s_axis_tdata,
  // [0] command
  input  logic                          s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [9:0] slot_index, [19:10] done_sq_slot, [20] doorbell_valid,
  // [84:21] doorbell_word, rest zero
  output logic [scr_pkg::OutDataW-1:0]  m_axis_tdata,
  // [2:0] outcome
  output logic [scr_pkg::OutcomeW-1:0]  m_axis_tuser,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scr_pkg::AddrW-1:0]     paddr,
  input  logic [scr_pkg::DataW-1:0]     pwdata,
  output logic [scr_pkg::DataW-1:0]     prdata,
  output logic                          pready
);
  import scr_pkg::*;

  cfg_t    cfg;
  item_t   in_item_q;
  logic    in_valid_q;
  result_t res_d, res_q;
  logic    out_valid_q;
  logic    out_free;
  logic    step;
  logic    in_xfer;

  scr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake control
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q.command       <= command_e'(s_axis_tuser);
      in_item_q.entry_phase   <= s_axis_tdata[0];
      in_item_q.entry_sq_slot <= s_axis_tdata[10:1];
      in_item_q.entry_status  <= s_axis_tdata[18:11];
    end
  end

  scr_engine #(
    .RING_DEPTH (RING_DEPTH)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.outcome;
  assign m_axis_tdata  = {3'b000, res_q.doorbell_word, res_q.doorbell_valid,
                          res_q.done_sq_slot, res_q.slot_index};

  // checks
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input not ready while input register empty");

  a_doorbell_on_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.doorbell_valid ==
                     (res_q.outcome == OUT_SUBMITTED || res_q.outcome == OUT_CPL_OK)))
    else $error("doorbell flag does not match outcome");

  a_idle_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.doorbell_valid) |-> (res_q.doorbell_word == '0))
    else $error("doorbell word set without doorbell");

  a_step_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed item produced no result");

endmodule
